// ===== rtl/sdc_pkg.sv =====
// Shared types, constants and codes of the straight-drive distance controller.
package sdc_pkg;

  localparam int ENCODER_BITS_DEF = 24;
  localparam int TARGET_W         = 20;
  localparam int DGAIN_W          = 10;
  localparam int HGAIN_W          = 11;
  localparam int HEAD_W           = 13;
  localparam int HMAG_W           = 13;
  localparam int PMAG_W           = 7;
  localparam int POWER_W          = 8;
  localparam int TRAVEL_W         = 23;
  localparam int TICK_W           = 10;
  localparam int SETTLE_W         = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 20;
  localparam int MUL_B_W          = 17;
  localparam int CORR_W           = 16;
  localparam int DIVX_W           = 15;
  localparam int Q_SHIFT          = 8;

  localparam int SETTLE_TICKS     = 2;
  localparam int SETTLE_BAND      = 8;
  localparam int DEADZONE         = 8;
  localparam int POWER_LIMIT      = 127;
  localparam int TRAVEL_MAX       = 8388607;

  // x/127 for x < 127*256: (x * DIV127_K) >> DIV127_SHIFT
  localparam int DIV127_K         = 33027;
  localparam int DIV127_SHIFT     = 22;
  localparam int DIV127_LIMIT     = 32512;
  // x*49/50 for x < 256: (x * TRIM_K) >> TRIM_SHIFT
  localparam int TRIM_K           = 1027628;
  localparam int TRIM_SHIFT       = 20;

  localparam int RST_DGAIN        = 61;
  localparam int RST_HGAIN        = 461;
  localparam int RST_MIN_POWER    = 17;
  localparam int RST_MAX_POWER    = 102;
  localparam int RST_TIMEOUT      = 275;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 3'd0,
    REG_DGAIN   = 3'd1,
    REG_HGAIN   = 3'd2,
    REG_HREF    = 3'd3,
    REG_MIN_PWR = 3'd4,
    REG_MAX_PWR = 3'd5,
    REG_REVERSE = 3'd6,
    REG_TIMEOUT = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_EVAL,
    ST_SPD,
    ST_CORR,
    ST_FACT,
    ST_LMUL,
    ST_RMUL,
    ST_LDIV,
    ST_RDIV,
    ST_TRIM,
    ST_TMUL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_SPD,
    MOP_CORR,
    MOP_LEFT,
    MOP_RIGHT,
    MOP_LDIV,
    MOP_RDIV,
    MOP_TRIM
  } mop_t;

  typedef struct packed {
    logic in_acc;
    logic fin;
    logic out_free;
  } sts_t;

  typedef struct packed {
    mop_t mop;
    logic busy;
    logic cap_avg;
    logic cap_eval;
    logic cap_spd;
    logic cap_fact;
    logic cap_lp;
    logic cap_rp;
    logic cap_lq;
    logic cap_rq;
    logic load_out;
  } ctl_t;

endpackage

// ===== rtl/sdc_mul.sv =====
// Shared unsigned multiplier with registered product.
module sdc_mul import sdc_pkg::*; #(
  parameter int A_W = TARGET_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p_r
);

  logic [A_W+B_W-1:0] p_nxt;

  assign p_nxt = (A_W+B_W)'(a) * (A_W+B_W)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ===== rtl/sdc_ctrl.sv =====
// Step sequencer of the controller: walks one transaction through the multiplier.
module sdc_ctrl import sdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_acc) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.fin ? ST_DONE : ST_SPD;
      ST_SPD:  state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_FACT;
      ST_FACT: state_nxt = ST_LMUL;
      ST_LMUL: state_nxt = ST_RMUL;
      ST_RMUL: state_nxt = ST_LDIV;
      ST_LDIV: state_nxt = ST_RDIV;
      ST_RDIV: state_nxt = ST_TRIM;
      ST_TRIM: state_nxt = ST_TMUL;
      ST_TMUL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mop      = MOP_NONE;
    ctl.busy     = (state_r != ST_IDLE);
    case (state_r)
      ST_AVG:  ctl.cap_avg = 1'b1;
      ST_EVAL: ctl.cap_eval = 1'b1;
      ST_SPD:  ctl.mop = MOP_SPD;
      ST_CORR: begin
        ctl.mop     = MOP_CORR;
        ctl.cap_spd = 1'b1;
      end
      ST_FACT: ctl.cap_fact = 1'b1;
      ST_LMUL: ctl.mop = MOP_LEFT;
      ST_RMUL: begin
        ctl.mop    = MOP_RIGHT;
        ctl.cap_lp = 1'b1;
      end
      ST_LDIV: begin
        ctl.mop    = MOP_LDIV;
        ctl.cap_rp = 1'b1;
      end
      ST_RDIV: begin
        ctl.mop    = MOP_RDIV;
        ctl.cap_lq = 1'b1;
      end
      ST_TRIM: ctl.cap_rq = 1'b1;
      ST_TMUL: ctl.mop = MOP_TRIM;
      ST_DONE: ctl.load_out = sts.out_free;
      default: ctl.mop = MOP_NONE;
    endcase
  end

endmodule

// ===== rtl/straight_drive_distance_controller_unit.sv =====
// Top level of the straight-drive distance controller: ports, registers, datapath.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall | start_req, left/right_count, heading
//  out_    | output    | out_valid/out_stall | left/right_power, done_res, travelled_counts
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A transaction walks twelve sequencer steps while a run is active; once the run is
// finished it goes straight from evaluation to the final step. Seven of the steps are
// products on the one shared multiplier (24x17 at the default encoder width).
// in_stall is high from the accepting edge until the result enters the output register;
// a held result does not block the next input transaction, only its final load.
// Synchronous active-low reset: sequencer idle, counters cleared, run finished,
// registers at their defaults. cfg_ready is always high.
module straight_drive_distance_controller_unit import sdc_pkg::*; #(
  parameter int ENCODER_BITS = ENCODER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_start_req,
  input  logic signed [ENCODER_BITS-1:0] in_left_count,
  input  logic signed [ENCODER_BITS-1:0] in_right_count,
  input  logic signed [HEAD_W-1:0]     in_heading,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [POWER_W-1:0]    out_left_power,
  output logic signed [POWER_W-1:0]    out_right_power,
  output logic                         out_done_res,
  output logic [TRAVEL_W-1:0]          out_travelled_counts,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int EB = ENCODER_BITS;
  localparam int MW = (EB > TARGET_W) ? EB : TARGET_W;
  localparam int PW = MW + MUL_B_W;
  localparam int XW = (EB > TRAVEL_W) ? EB : TRAVEL_W;

  // configuration registers
  logic [TARGET_W-1:0]     target_r;
  logic [DGAIN_W-1:0]      dgain_r;
  logic [HGAIN_W-1:0]      hgain_r;
  logic [HEAD_W-1:0]       href_r;
  logic [PMAG_W-1:0]       min_pwr_r;
  logic [PMAG_W-1:0]       max_pwr_r;
  logic                    rev_r;
  logic [TICK_W-1:0]       timeout_r;

  // run state
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [SETTLE_W-1:0]     settle_r, settle_nxt;
  logic                    fin_r, fin_nxt;

  // latched transaction
  logic                    start_r;
  logic [EB-1:0]           lc_r, rc_r;
  logic [HEAD_W-1:0]       hd_r;

  // working registers
  logic [EB-1:0]           avg_r;
  logic [TRAVEL_W-1:0]     trav_r;
  logic [HMAG_W-1:0]       hd_mag_r;
  logic                    hd_neg_r;
  logic [MW-1:0]           abs_err_r;
  logic                    err_neg_r;
  logic                    done_r;
  logic [PMAG_W-1:0]       spd_r;
  logic [MUL_B_W-1:0]      fl_mag_r, fr_mag_r;
  logic                    fl_neg_r, fr_neg_r;
  logic                    l_big_r, r_big_r;
  logic [DIVX_W-1:0]       l_x_r, r_x_r;
  logic [PMAG_W-1:0]       l_mag_r;
  logic [POWER_W-1:0]      r_dz_r;

  // output register
  logic                    out_valid_r;
  logic [POWER_W-1:0]      out_lp_r, out_rp_r;
  logic                    out_done_r;
  logic [TRAVEL_W-1:0]     out_trav_r;

  ctl_t                    ctl;
  sts_t                    sts;
  logic                    in_acc;

  logic [MW-1:0]           mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PW-1:0]           mul_p;

  // averaging
  logic [EB-1:0]           abs_l, abs_r;
  logic [EB:0]             cnt_sum;
  logic [XW-1:0]           avg_x;
  logic [HMAG_W:0]         hdiff;

  // evaluation
  logic [MW:0]             err_s;
  logic [MW-1:0]           err_mag;
  logic [TICK_W-1:0]       tick0;
  logic [SETTLE_W-1:0]     settle0;
  logic                    pre_fin;

  // capture helpers
  logic [PMAG_W-1:0]       spd_raw, spd_lift;
  logic [CORR_W-1:0]       corr_mag;
  logic [MUL_B_W-1:0]      corr_ext, fac_sum, fac_dif;
  logic                    corr_big;
  logic [POWER_W-1:0]      q_raw, q_dz;
  logic [POWER_W-1:0]      t_raw;
  logic [PMAG_W-1:0]       r_mag;
  logic                    l_neg, r_neg;
  logic [POWER_W-1:0]      lp_val, rp_val;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = ctl.busy;
  assign cfg_ready = 1'b1;

  assign sts.in_acc   = in_acc;
  assign sts.fin      = fin_nxt;
  assign sts.out_free = !out_valid_r || !out_stall;

  sdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  sdc_mul #(
    .A_W (MW),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .en  (ctl.mop != MOP_NONE),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mop)
      MOP_SPD: begin
        mul_a = abs_err_r;
        mul_b = MUL_B_W'(dgain_r);
      end
      MOP_CORR: begin
        mul_a = MW'(hd_mag_r);
        mul_b = MUL_B_W'(hgain_r);
      end
      MOP_LEFT: begin
        mul_a = MW'(spd_r);
        mul_b = fl_mag_r;
      end
      MOP_RIGHT: begin
        mul_a = MW'(spd_r);
        mul_b = fr_mag_r;
      end
      MOP_LDIV: begin
        mul_a = MW'(l_x_r);
        mul_b = MUL_B_W'(DIV127_K);
      end
      MOP_RDIV: begin
        mul_a = MW'(r_x_r);
        mul_b = MUL_B_W'(DIV127_K);
      end
      MOP_TRIM: begin
        mul_a = MW'(TRIM_K);
        mul_b = MUL_B_W'(r_dz_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      dgain_r   <= DGAIN_W'(RST_DGAIN);
      hgain_r   <= HGAIN_W'(RST_HGAIN);
      href_r    <= '0;
      min_pwr_r <= PMAG_W'(RST_MIN_POWER);
      max_pwr_r <= PMAG_W'(RST_MAX_POWER);
      rev_r     <= 1'b0;
      timeout_r <= TICK_W'(RST_TIMEOUT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET:  target_r  <= cfg_data[TARGET_W-1:0];
        REG_DGAIN:   dgain_r   <= cfg_data[DGAIN_W-1:0];
        REG_HGAIN:   hgain_r   <= cfg_data[HGAIN_W-1:0];
        REG_HREF:    href_r    <= cfg_data[HEAD_W-1:0];
        REG_MIN_PWR: min_pwr_r <= cfg_data[PMAG_W-1:0];
        REG_MAX_PWR: max_pwr_r <= cfg_data[PMAG_W-1:0];
        REG_REVERSE: rev_r     <= cfg_data[0];
        REG_TIMEOUT: timeout_r <= cfg_data[TICK_W-1:0];
        default:     rev_r     <= rev_r;
      endcase
    end
  end

  // averaging and heading error
  assign abs_l   = lc_r[EB-1] ? (~lc_r + 1'b1) : lc_r;
  assign abs_r   = rc_r[EB-1] ? (~rc_r + 1'b1) : rc_r;
  assign cnt_sum = {1'b0, abs_l} + {1'b0, abs_r};
  assign avg_x   = XW'(cnt_sum[EB:1]);
  assign hdiff   = {href_r[HEAD_W-1], href_r} - {hd_r[HEAD_W-1], hd_r};

  // run bookkeeping
  assign err_s   = (MW+1)'(target_r) - (MW+1)'(avg_r);
  assign err_mag = err_s[MW] ? MW'(~err_s + 1'b1) : err_s[MW-1:0];
  assign tick0   = start_r ? '0 : tick_r;
  assign settle0 = start_r ? '0 : settle_r;
  assign pre_fin = (start_r ? 1'b0 : fin_r) || (tick0 >= timeout_r);

  always_comb begin
    tick_nxt   = tick0;
    settle_nxt = settle0;
    fin_nxt    = 1'b1;
    if (!pre_fin) begin
      if (err_mag > MW'(SETTLE_BAND)) begin
        settle_nxt = '0;
      end else if (!(&settle0)) begin
        settle_nxt = settle0 + 1'b1;
      end
      if (!(&tick0)) begin
        tick_nxt = tick0 + 1'b1;
      end
      fin_nxt = (settle_nxt >= SETTLE_W'(SETTLE_TICKS)) || (tick_nxt >= timeout_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      settle_r <= '0;
      fin_r    <= 1'b1;
    end else if (ctl.cap_eval) begin
      tick_r   <= tick_nxt;
      settle_r <= settle_nxt;
      fin_r    <= fin_nxt;
    end
  end

  // speed lift and clamp
  assign spd_raw  = (|mul_p[PW-1:Q_SHIFT+PMAG_W]) ? PMAG_W'(POWER_LIMIT)
                                                 : mul_p[Q_SHIFT+PMAG_W-1:Q_SHIFT];
  assign spd_lift = (spd_raw < min_pwr_r) ? min_pwr_r : spd_raw;

  // steering factors 127 - corr and 127 + corr
  assign corr_mag = mul_p[Q_SHIFT+CORR_W-1:Q_SHIFT];
  assign corr_ext = MUL_B_W'(corr_mag);
  assign corr_big = corr_mag > CORR_W'(POWER_LIMIT);
  assign fac_sum  = corr_ext + MUL_B_W'(POWER_LIMIT);
  assign fac_dif  = corr_big ? (corr_ext - MUL_B_W'(POWER_LIMIT))
                             : (MUL_B_W'(POWER_LIMIT) - corr_ext);

  // quotient by 127 (below 256 here), then deadzone
  assign q_raw = mul_p[DIV127_SHIFT+POWER_W-1:DIV127_SHIFT];
  assign q_dz  = (q_raw < POWER_W'(DEADZONE)) ? '0 : q_raw;

  assign t_raw = mul_p[TRIM_SHIFT+POWER_W-1:TRIM_SHIFT];
  assign r_mag = t_raw[POWER_W-1] ? PMAG_W'(POWER_LIMIT) : t_raw[PMAG_W-1:0];

  assign l_neg  = err_neg_r ^ fl_neg_r ^ rev_r;
  assign r_neg  = err_neg_r ^ fr_neg_r ^ rev_r;
  assign lp_val = done_r ? '0 : (l_neg ? (~{1'b0, l_mag_r} + 1'b1) : {1'b0, l_mag_r});
  assign rp_val = done_r ? '0 : (r_neg ? (~{1'b0, r_mag} + 1'b1) : {1'b0, r_mag});

  always_ff @(posedge clk) begin
    if (in_acc) begin
      start_r <= in_start_req;
      lc_r    <= in_left_count;
      rc_r    <= in_right_count;
      hd_r    <= in_heading;
    end
    if (ctl.cap_avg) begin
      avg_r    <= cnt_sum[EB:1];
      trav_r   <= (avg_x > XW'(TRAVEL_MAX)) ? TRAVEL_W'(TRAVEL_MAX) : avg_x[TRAVEL_W-1:0];
      hd_neg_r <= hdiff[HMAG_W];
      hd_mag_r <= hdiff[HMAG_W] ? HMAG_W'(~hdiff + 1'b1) : hdiff[HMAG_W-1:0];
    end
    if (ctl.cap_eval) begin
      abs_err_r <= err_mag;
      err_neg_r <= err_s[MW];
      done_r    <= fin_nxt;
    end
    if (ctl.cap_spd) begin
      if (spd_raw == '0) begin
        spd_r <= '0;
      end else begin
        spd_r <= (spd_lift > max_pwr_r) ? max_pwr_r : spd_lift;
      end
    end
    if (ctl.cap_fact) begin
      if (hd_neg_r) begin
        fl_mag_r <= fac_sum;
        fl_neg_r <= 1'b0;
        fr_mag_r <= fac_dif;
        fr_neg_r <= corr_big;
      end else begin
        fl_mag_r <= fac_dif;
        fl_neg_r <= corr_big;
        fr_mag_r <= fac_sum;
        fr_neg_r <= 1'b0;
      end
    end
    if (ctl.cap_lp) begin
      l_big_r <= mul_p >= PW'(DIV127_LIMIT);
      l_x_r   <= mul_p[DIVX_W-1:0];
    end
    if (ctl.cap_rp) begin
      r_big_r <= mul_p >= PW'(DIV127_LIMIT);
      r_x_r   <= mul_p[DIVX_W-1:0];
    end
    if (ctl.cap_lq) begin
      if (l_big_r) begin
        l_mag_r <= PMAG_W'(POWER_LIMIT);
      end else begin
        l_mag_r <= q_dz[POWER_W-1] ? PMAG_W'(POWER_LIMIT) : q_dz[PMAG_W-1:0];
      end
    end
    if (ctl.cap_rq) begin
      r_dz_r <= r_big_r ? '1 : q_dz;
    end
    if (ctl.load_out) begin
      out_lp_r   <= lp_val;
      out_rp_r   <= rp_val;
      out_done_r <= done_r;
      out_trav_r <= trav_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_power       = out_lp_r;
  assign out_right_power      = out_rp_r;
  assign out_done_res         = out_done_r;
  assign out_travelled_counts = out_trav_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while sequencer stays idle");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a held transaction");

  a_done_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_done_res || (out_left_power == '0 && out_right_power == '0)))
    else $error("finished run drives nonzero power");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_power != 8'sh80 && out_right_power != 8'sh80))
    else $error("side power beyond limit");

endmodule

// ===== tb/sv/tb_straight_drive_distance_controller_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the straight-drive distance controller unit.
module tb_straight_drive_distance_controller_unit;
  import sdc_pkg::*;

  localparam int ENC_W           = ENCODER_BITS_DEF;
  localparam int ENC_MAX         = 8388607;
  localparam int ENC_MIN         = -8388608;
  localparam int HEAD_MAX        = 3600;
  localparam int DIR_ROWS        = 21;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int TAIL_CYCLES     = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 40;

  typedef struct packed {
    logic [POWER_W-1:0]  left_power;
    logic [POWER_W-1:0]  right_power;
    logic                done;
    logic [TRAVEL_W-1:0] travelled;
  } drive_cmd_t;

  typedef struct {
    bit         start;
    int         left;
    int         right;
    int         heading;
    bit         typed;
    drive_cmd_t cmd;
  } drive_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_start_req = 1'b0;
  logic signed [ENC_W-1:0]  in_left_count = '0;
  logic signed [ENC_W-1:0]  in_right_count = '0;
  logic signed [HEAD_W-1:0] in_heading = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POWER_W-1:0] out_left_power;
  logic signed [POWER_W-1:0] out_right_power;
  logic                     out_done_res;
  logic [TRAVEL_W-1:0]      out_travelled_counts;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // controller copy of the register file and run state
  logic [TARGET_W-1:0]      p_target = '0;
  logic [DGAIN_W-1:0]       p_dgain = DGAIN_W'(RST_DGAIN);
  logic [HGAIN_W-1:0]       p_hgain = HGAIN_W'(RST_HGAIN);
  logic signed [HEAD_W-1:0] p_href = '0;
  logic [PMAG_W-1:0]        p_min = PMAG_W'(RST_MIN_POWER);
  logic [PMAG_W-1:0]        p_max = PMAG_W'(RST_MAX_POWER);
  logic                     p_rev = 1'b0;
  logic [TICK_W-1:0]        p_timeout = TICK_W'(RST_TIMEOUT);
  int unsigned              tick_cnt = 0;
  int unsigned              settle_cnt = 0;
  bit                       run_over = 1'b1;

  drive_cmd_t pending_cmds[$];
  drive_row_t dir_tbl[DIR_ROWS];

  int items_sent = 0;
  int cmds_checked = 0;
  int mismatches = 0;
  int settings_applied = 0;
  int runs_started = 0;
  int runs_settled = 0;
  int runs_timed_out = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 53;
  int hold_left = 0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  straight_drive_distance_controller_unit #(
    .ENCODER_BITS(ENC_W)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_req         (in_start_req),
    .in_left_count        (in_left_count),
    .in_right_count       (in_right_count),
    .in_heading           (in_heading),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_power       (out_left_power),
    .out_right_power      (out_right_power),
    .out_done_res         (out_done_res),
    .out_travelled_counts (out_travelled_counts),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip_power(longint v);
    if (v > POWER_LIMIT) return POWER_LIMIT;
    if (v < -POWER_LIMIT) return -POWER_LIMIT;
    return v;
  endfunction

  function automatic longint dead_band(longint v);
    return mag(v) < DEADZONE ? 0 : v;
  endfunction

  // motor command for one control tick; advances the run state
  function automatic drive_cmd_t drive_cmd_for(bit start, logic signed [ENC_W-1:0] lc,
                                               logic signed [ENC_W-1:0] rc,
                                               logic signed [HEAD_W-1:0] hd);
    longint l, r, h, travel, err, spd, corr, lp, rp, lo, hi;
    drive_cmd_t c;
    l = lc;
    r = rc;
    h = hd;
    travel = (mag(l) + mag(r)) / 2;
    lp = 0;
    rp = 0;
    if (start) begin
      tick_cnt = 0;
      settle_cnt = 0;
      run_over = 1'b0;
      runs_started++;
    end
    if (!run_over && tick_cnt >= p_timeout) begin
      run_over = 1'b1;
      runs_timed_out++;
    end
    if (!run_over) begin
      err = longint'(p_target) - travel;
      spd = err * longint'(p_dgain) / 256;
      corr = (longint'(p_href) - h) * longint'(p_hgain) / 256;
      lo = p_min;
      hi = p_max;
      if (spd > 0 && spd < lo) spd = lo;
      else if (spd < 0 && spd > -lo) spd = -lo;
      if (spd > hi) spd = hi;
      else if (spd < -hi) spd = -hi;
      lp = spd * (127 - corr) / 127;
      rp = spd * (127 + corr) / 127;
      if (p_rev) begin
        lp = -lp;
        rp = -rp;
      end
      lp = clip_power(dead_band(lp));
      rp = clip_power(dead_band(rp) * 49 / 50);
      if (mag(err) > SETTLE_BAND) settle_cnt = 0;
      else if (settle_cnt < 3) settle_cnt++;
      if (tick_cnt < 1023) tick_cnt++;
      if (settle_cnt >= SETTLE_TICKS || tick_cnt >= p_timeout) begin
        run_over = 1'b1;
        lp = 0;
        rp = 0;
        if (settle_cnt >= SETTLE_TICKS) runs_settled++;
        else runs_timed_out++;
      end
    end
    if (travel > TRAVEL_MAX) travel = TRAVEL_MAX;
    c.left_power = lp[POWER_W-1:0];
    c.right_power = rp[POWER_W-1:0];
    c.done = run_over;
    c.travelled = travel[TRAVEL_W-1:0];
    return c;
  endfunction

  function automatic void note_mismatch(string what, logic signed [31:0] want,
                                        logic signed [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TARGET:  p_target = d[TARGET_W-1:0];
      REG_DGAIN:   p_dgain = d[DGAIN_W-1:0];
      REG_HGAIN:   p_hgain = d[HGAIN_W-1:0];
      REG_HREF:    p_href = d[HEAD_W-1:0];
      REG_MIN_PWR: p_min = d[PMAG_W-1:0];
      REG_MAX_PWR: p_max = d[PMAG_W-1:0];
      REG_REVERSE: p_rev = d[0];
      REG_TIMEOUT: p_timeout = d[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int ph);
    int tgt, dg, hg, hr, mn, mx, rv, to;
    tgt = ($urandom_range(3) == 0) ? $urandom_range(0, 1048575) : $urandom_range(0, 5000);
    dg = $urandom_range(0, 1023);
    hg = $urandom_range(0, 2047);
    hr = int'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX;
    mn = $urandom_range(0, 127);
    mx = $urandom_range(0, 127);
    rv = $urandom_range(0, 1);
    to = $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
    case (ph)
      0: begin                    // zero timeout
        dg = RST_DGAIN;
        to = 0;
      end
      1: begin                    // min above max
        mn = 90;
        mx = 40;
        to = 1023;
      end
      2: begin
        tgt = 1048575;
        dg = 1023;
        hg = 2047;
        hr = HEAD_MAX;
        mn = 127;
        mx = 127;
        rv = 1;
        to = 1023;
      end
      3: begin
        tgt = 0;
        dg = 0;
        hg = 0;
        hr = -HEAD_MAX;
        mn = 0;
        mx = 0;
        rv = 0;
        to = 1;
      end
      default: ;
    endcase
    write_reg(REG_TARGET, tgt[CFG_DATA_W-1:0]);
    write_reg(REG_DGAIN, dg[CFG_DATA_W-1:0]);
    write_reg(REG_HGAIN, hg[CFG_DATA_W-1:0]);
    write_reg(REG_HREF, hr[CFG_DATA_W-1:0]);
    write_reg(REG_MIN_PWR, mn[CFG_DATA_W-1:0]);
    write_reg(REG_MAX_PWR, mx[CFG_DATA_W-1:0]);
    write_reg(REG_REVERSE, rv[CFG_DATA_W-1:0]);
    write_reg(REG_TIMEOUT, to[CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic offer(bit st, int l, int r, int h, bit typed, drive_cmd_t cmd);
    drive_cmd_t c;
    in_valid <= 1'b1;
    in_start_req <= st;
    in_left_count <= l[ENC_W-1:0];
    in_right_count <= r[ENC_W-1:0];
    in_heading <= h[HEAD_W-1:0];
    do @(posedge clk); while (in_stall);
    c = drive_cmd_for(st, l[ENC_W-1:0], r[ENC_W-1:0], h[HEAD_W-1:0]);
    pending_cmds.push_back(typed ? cmd : c);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    wait (pending_cmds.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none pending", $time);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked++;
        if (out_left_power !== want.left_power)
          note_mismatch("left_power", $signed(want.left_power), out_left_power);
        if (out_right_power !== want.right_power)
          note_mismatch("right_power", $signed(want.right_power), out_right_power);
        if (out_done_res !== want.done)
          note_mismatch("done_res", want.done, out_done_res);
        if (out_travelled_counts !== want.travelled)
          note_mismatch("travelled_counts", want.travelled, out_travelled_counts);
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int i, ph, n, k, len, pos, spread, hdg, tgt, sgn;
    bit hold_done, pause_done;
    dir_tbl = '{
      '{1'b0, 0,       0,       0,         1'b1, '{8'd0, 8'd0, 1'b1, 23'd0}},
      '{1'b0, ENC_MAX, ENC_MAX, HEAD_MAX,  1'b1, '{8'd0, 8'd0, 1'b1, 23'd8388607}},
      '{1'b0, ENC_MIN, ENC_MIN, -HEAD_MAX, 1'b1, '{8'd0, 8'd0, 1'b1, 23'd8388607}},
      '{1'b0, ENC_MIN, 0,       0,         1'b1, '{8'd0, 8'd0, 1'b1, 23'd4194304}},
      '{1'b1, 1000,    1000,    0,         1'b0, '0},
      '{1'b0, 800,     -800,    HEAD_MAX,  1'b0, '0},
      '{1'b0, 600,     600,     -HEAD_MAX, 1'b0, '0},
      '{1'b0, 300,     300,     100,       1'b0, '0},
      '{1'b0, 40,      40,      0,         1'b0, '0},
      '{1'b0, 50,      50,      -40,       1'b0, '0},
      '{1'b0, 20,      20,      -20,       1'b0, '0},
      '{1'b0, 5,       -5,      0,         1'b0, '0},
      '{1'b0, 3,       3,       0,         1'b0, '0},
      '{1'b0, 3,       3,       0,         1'b1, '{8'd0, 8'd0, 1'b1, 23'd3}},
      '{1'b1, 9,       9,       0,         1'b0, '0},
      '{1'b1, 8,       8,       0,         1'b0, '0},
      '{1'b0, 0,       0,       0,         1'b0, '0},
      '{1'b1, ENC_MAX, ENC_MAX, 0,         1'b0, '0},
      '{1'b1, ENC_MIN, ENC_MIN, HEAD_MAX,  1'b0, '0},
      '{1'b0, ENC_MAX, ENC_MIN, -HEAD_MAX, 1'b0, '0},
      '{1'b0, -1,      1,       -1,        1'b0, '0}
    };
    hold_done = 1'b0;
    pause_done = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      offer(dir_tbl[i].start, dir_tbl[i].left, dir_tbl[i].right, dir_tbl[i].heading,
            dir_tbl[i].typed, dir_tbl[i].cmd);
    in_valid <= 1'b0;
    drain_results();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 53;
      end else if (ph < 8) begin
        send_idle_pct = 53;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(ph);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if (ph == 5 && n >= 20 && !hold_done) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 7 && n >= 26 && !pause_done) begin
          in_valid <= 1'b0;
          wait (pending_cmds.size() == 0);
          @(posedge clk);
          pause_done = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          // one drive: ramp toward the target, then a few ticks inside the band
          len = $urandom_range(3, 20);
          tgt = p_target;
          sgn = p_rev ? -1 : 1;
          for (k = 0; k < len + 3; k++) begin
            if (k < len) pos = tgt * k / len + int'($urandom_range(30)) - 15;
            else pos = tgt + int'($urandom_range(16)) - 8;
            spread = $urandom_range(0, 12);
            hdg = p_href + int'($urandom_range(100)) - 50;
            if ($urandom_range(15) == 0) hdg = int'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX;
            if (hdg > HEAD_MAX) hdg = HEAD_MAX;
            if (hdg < -HEAD_MAX) hdg = -HEAD_MAX;
            if ($urandom_range(9) == 0) sgn = -sgn;
            offer(k == 0, sgn * (pos + spread), sgn * (pos - spread), hdg, 1'b0, '0);
            n++;
          end
        end else begin
          offer($urandom_range(7) == 0, $urandom, $urandom,
                int'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX, 1'b0, '0);
          n++;
        end
      end
      in_valid <= 1'b0;
      drain_results();
    end

    $display("Covered %0d transactions under %0d register settings",
             items_sent, settings_applied + 1);
    $display("  %0d runs, %0d settled, %0d timed out",
             runs_started, runs_settled, runs_timed_out);
    if (mismatches == 0 && cmds_checked == items_sent)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
